@@ rtl/core/audio_block_level_meter_assert.svh @@
// Assertion macros for the level meter checkers.
// Sample the consequent in the same cycle as the antecedent.
`ifndef AUDIO_BLOCK_LEVEL_METER_ASSERT_SVH
`define AUDIO_BLOCK_LEVEL_METER_ASSERT_SVH

`define ABL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level meter port check failed");

// Sample the consequent in the cycle after the antecedent.
`define ABL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level meter port check failed");

`endif

@@ rtl/core/abl_pkg.sv @@
package abl_pkg;

    localparam int MAX_FRAMES_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int SMP_W = 24;
    localparam int LVL_W = 24;
    localparam int THR_W = 24;
    localparam int CH_W  = 2;
    localparam int SUM_W = 60;
    localparam int SQ_W  = 2 * LVL_W;
    localparam int RT_W  = SUM_W / 2;
    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [CH_W-1:0]  CH_MAX       = 2'd2;
    localparam logic [CH_W-1:0]  ACT_CH_RST   = 2'd2;
    // about 0.9995 of full scale
    localparam logic [THR_W-1:0] CLIP_THR_RST = 24'd8384415;
    localparam logic [LVL_W-1:0] FULL_SCALE   = 24'h800000;
    localparam logic [SUM_W-1:0] SUM_MAX      = '1;

    typedef enum logic [0:0] {
        REG_ACTIVE_CHANNELS = 1'b0,
        REG_CLIP_THRESHOLD  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SMP_W-1:0] first_sample;
        logic signed [SMP_W-1:0] second_sample;
        logic                    last_in_block;
    } t_frame;

    typedef struct packed {
        logic [LVL_W-1:0] rms_level;
        logic [LVL_W-1:0] peak_level;
        logic             clip_flag;
    } t_level;

    typedef struct packed {
        t_cfg_reg         index;
        logic [THR_W-1:0] data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear_blk;
        logic div_start;
        logic div_step;
        logic root_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic root_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/abl_stream_if.sv @@
interface abl_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/abl_accum.sv @@
module abl_accum #(
    parameter int MAX_FRAMES  = abl_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = abl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  abl_pkg::t_cmd                     i_cmd,
    input  abl_pkg::t_frame                   i_frame,
    input  logic [abl_pkg::CH_W-1:0]          i_active_ch,
    output logic [abl_pkg::SUM_W-1:0]         o_sum,
    output logic [abl_pkg::LVL_W-1:0]         o_peak,
    output logic [$clog2(MAX_FRAMES+1)-1:0]   o_count,
    output logic [abl_pkg::CH_W-1:0]          o_ch
);

    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int MW  = (SAMPLE_BITS > abl_pkg::SMP_W) ? SAMPLE_BITS : abl_pkg::SMP_W;
    localparam int SXW = abl_pkg::SUM_W + 1;

    // Sign-extend from the sample's top bit, take the magnitude, clamp at full scale.
    function automatic logic [abl_pkg::LVL_W-1:0] f_mag(input logic [abl_pkg::SMP_W-1:0] raw);
        logic [MW-1:0]          v;
        logic [SAMPLE_BITS-1:0] s;
        logic [SAMPLE_BITS-1:0] s_neg;
        logic [MW-1:0]          m;
        v     = MW'(raw);
        s     = v[SAMPLE_BITS-1:0];
        s_neg = ~s + 1'b1;
        m     = s[SAMPLE_BITS-1] ? MW'(s_neg) : MW'(s);
        if (m > MW'(abl_pkg::FULL_SCALE)) begin
            return abl_pkg::FULL_SCALE;
        end
        return m[abl_pkg::LVL_W-1:0];
    endfunction

    logic [abl_pkg::LVL_W-1:0] r_m1, n_m1, r_m2, n_m2;
    logic [abl_pkg::SQ_W-1:0]  r_sq1, r_sq2;
    logic [abl_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [abl_pkg::LVL_W-1:0] r_peak, n_peak;
    logic [FCW-1:0]            r_count, n_count;
    logic [abl_pkg::CH_W-1:0]  r_ch, n_ch;

    logic [abl_pkg::CH_W-1:0]  ch;
    logic [abl_pkg::LVL_W-1:0] mag1, mag2;
    logic                      room, use1, use2;
    logic [SXW-1:0]            sum_ext;

    always_comb begin
        ch      = (i_active_ch > abl_pkg::CH_MAX) ? abl_pkg::CH_MAX : i_active_ch;
        mag1    = f_mag(i_frame.first_sample);
        mag2    = f_mag(i_frame.second_sample);
        room    = r_count < FCW'(MAX_FRAMES);
        use1    = (ch != '0) && room;
        use2    = (ch == abl_pkg::CH_MAX) && room;
        n_m1    = '0;
        n_m2    = '0;
        n_peak  = r_peak;
        n_count = r_count;
        n_ch    = r_ch;
        if (i_cmd.accept) begin
            n_ch = ch;
            if (use1) begin
                n_m1    = mag1;
                n_count = r_count + 1'b1;
            end
            if (use2) begin
                n_m2 = mag2;
            end
            if ((ch != '0) && (mag1 > n_peak)) begin
                n_peak = mag1;
            end
            if ((ch == abl_pkg::CH_MAX) && (mag2 > n_peak)) begin
                n_peak = mag2;
            end
        end
        // saturate the running sum of squares
        sum_ext = {1'b0, r_sum} + SXW'(r_sq1) + SXW'(r_sq2);
        n_sum   = (sum_ext > SXW'(abl_pkg::SUM_MAX)) ? abl_pkg::SUM_MAX
                                                     : sum_ext[abl_pkg::SUM_W-1:0];
        if (i_cmd.clear_blk) begin
            n_sum   = '0;
            n_peak  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1    <= '0;
            r_m2    <= '0;
            r_sq1   <= '0;
            r_sq2   <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
            r_count <= '0;
            r_ch    <= '0;
        end else begin
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_sq1   <= abl_pkg::SQ_W'(r_m1) * abl_pkg::SQ_W'(r_m1);
            r_sq2   <= abl_pkg::SQ_W'(r_m2) * abl_pkg::SQ_W'(r_m2);
            r_sum   <= n_sum;
            r_peak  <= n_peak;
            r_count <= n_count;
            r_ch    <= n_ch;
        end
    end

    assign o_sum   = r_sum;
    assign o_peak  = r_peak;
    assign o_count = r_count;
    assign o_ch    = r_ch;

endmodule

@@ rtl/core/abl_root.sv @@
module abl_root #(
    parameter int MAX_FRAMES = abl_pkg::MAX_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  abl_pkg::t_cmd                     i_cmd,
    input  logic [abl_pkg::SUM_W-1:0]         i_sum,
    input  logic [abl_pkg::LVL_W-1:0]         i_peak,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]   i_count,
    input  logic [abl_pkg::CH_W-1:0]          i_ch,
    input  logic [abl_pkg::THR_W-1:0]         i_clip_thr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output abl_pkg::t_level                   o_level,
    output abl_pkg::t_status                  o_status
);

    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int DVW = FCW + 1;
    localparam int RRW = abl_pkg::RT_W + 2;

    logic [abl_pkg::SUM_W-1:0] r_dvd;
    logic [DVW-1:0]            r_rem, r_dvs;
    logic                      r_dvs_zero;
    logic [abl_pkg::RT_W-1:0]  r_root;
    logic [RRW-1:0]            r_rrem;
    logic [abl_pkg::CNT_W-1:0] r_cnt;
    logic                      r_out_valid;
    abl_pkg::t_level           r_out;
    logic                      r_clip;

    logic [DVW:0]              rem_sh, rem_nx;
    logic                      q_bit;
    logic [RRW-1:0]            rrem_sh, trial;
    logic                      r_bit;
    logic                      div_last, root_last;
    logic                      clip_set, n_clip;
    logic [abl_pkg::LVL_W-1:0] rms;

    always_comb begin
        // restoring divide, one quotient bit a step
        rem_sh  = {r_rem, r_dvd[abl_pkg::SUM_W-1]};
        q_bit   = !r_dvs_zero && (rem_sh >= {1'b0, r_dvs});
        rem_nx  = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
        // digit-by-digit square root, two dividend bits a step
        rrem_sh = {r_rrem[RRW-3:0], r_dvd[abl_pkg::SUM_W-1 -: 2]};
        trial   = {r_root, 2'b01};
        r_bit   = rrem_sh >= trial;
        div_last  = r_cnt == abl_pkg::CNT_W'(abl_pkg::SUM_W - 1);
        root_last = r_cnt == abl_pkg::CNT_W'(abl_pkg::RT_W - 1);
        rms = (r_root > abl_pkg::RT_W'(abl_pkg::FULL_SCALE)) ? abl_pkg::FULL_SCALE
                                                            : r_root[abl_pkg::LVL_W-1:0];
        clip_set = (i_ch != '0) && (i_peak >= i_clip_thr);
        n_clip   = r_clip | clip_set;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd      <= i_sum;
            r_rem      <= '0;
            r_dvs      <= (i_ch == abl_pkg::CH_MAX) ? {i_count, 1'b0} : DVW'(i_count);
            r_dvs_zero <= (i_ch == '0) || (i_count == '0);
            r_root     <= '0;
            r_rrem     <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[abl_pkg::SUM_W-2:0], q_bit};
            r_rem <= rem_nx[DVW-1:0];
            r_cnt <= div_last ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.root_step) begin
            r_dvd  <= {r_dvd[abl_pkg::SUM_W-3:0], 2'b00};
            r_rrem <= r_bit ? (rrem_sh - trial) : rrem_sh;
            r_root <= {r_root[abl_pkg::RT_W-2:0], r_bit};
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out.rms_level  <= (i_ch == '0) ? '0 : rms;
            r_out.peak_level <= (i_ch == '0) ? '0 : i_peak;
            r_out.clip_flag  <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clip      <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_clip      <= n_clip;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_level            = r_out;
    assign o_status.div_last  = div_last;
    assign o_status.root_last = root_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/abl_ctrl.sv @@
module abl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  abl_pkg::t_status i_status,
    output logic             o_in_ready,
    output abl_pkg::t_cmd    o_cmd
);

    abl_pkg::t_state r_state, n_state;
    logic            r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abl_pkg::ST_RUN;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_drain    = r_drain;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            abl_pkg::ST_RUN: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = abl_pkg::ST_DRAIN;
                    n_drain = 1'b0;
                end
            end
            // let the square and sum stages settle
            abl_pkg::ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = abl_pkg::ST_LOAD;
                end
            end
            abl_pkg::ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = abl_pkg::ST_DIV;
            end
            abl_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = abl_pkg::ST_ROOT;
                end
            end
            abl_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = abl_pkg::ST_OUT;
                end
            end
            abl_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.clear_blk = 1'b1;
                    n_state         = abl_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = abl_pkg::ST_RUN;
            end
        endcase
    end

endmodule

@@ rtl/core/audio_block_level_meter.sv @@
// Frames inside a block: one item per cycle, accepted while the block collects.
// Block end: after the last frame is accepted the block drains the square and sum
// stages, loads the divider, runs 60 divide steps and 30 root steps, then loads the
// result item once the output register is free; no frames are taken meanwhile.
// Reset (i_rst_n, synchronous, active low) clears control, accumulators and the
// clip latch, and returns the registers to two channels and the default threshold.
module audio_block_level_meter #(
    parameter int MAX_FRAMES  = abl_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = abl_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    abl_stream_if.sink   i_frame,
    abl_stream_if.source o_level,
    abl_stream_if.sink   i_cfg
);

    localparam int FCW = $clog2(MAX_FRAMES + 1);

    // Configuration registers; writes are always taken.
    logic [abl_pkg::CH_W-1:0]  r_active_ch;
    logic [abl_pkg::THR_W-1:0] r_clip_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ch <= abl_pkg::ACT_CH_RST;
            r_clip_thr  <= abl_pkg::CLIP_THR_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.payload.index)
                abl_pkg::REG_ACTIVE_CHANNELS: begin
                    r_active_ch <= i_cfg.payload.data[abl_pkg::CH_W-1:0];
                end
                abl_pkg::REG_CLIP_THRESHOLD: begin
                    r_clip_thr <= i_cfg.payload.data;
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    abl_pkg::t_cmd             cmd;
    abl_pkg::t_status          status;
    logic                      in_ready;
    logic [abl_pkg::SUM_W-1:0] sum;
    logic [abl_pkg::LVL_W-1:0] peak;
    logic [FCW-1:0]            count;
    logic [abl_pkg::CH_W-1:0]  blk_ch;

    // Sequence the block: take frames, drain, divide, root, hand off the item.
    abl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frame.valid),
        .i_in_last  (i_frame.payload.last_in_block),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_frame.ready = in_ready;

    // Per-frame path: magnitudes, peak and frame count at accept, then square,
    // then saturating accumulate. The channel count in force at the last frame
    // sets the divisor.
    abl_accum #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_frame     (i_frame.payload),
        .i_active_ch (r_active_ch),
        .o_sum       (sum),
        .o_peak      (peak),
        .o_count     (count),
        .o_ch        (blk_ch)
    );

    // Block-end path: mean by long division, then integer square root on the
    // same shift register, then the output register and the sticky clip latch.
    // With no channels the levels read zero and the latch holds.
    abl_root #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_root (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sum       (sum),
        .i_peak      (peak),
        .i_count     (count),
        .i_ch        (blk_ch),
        .i_clip_thr  (r_clip_thr),
        .i_out_ready (o_level.ready),
        .o_out_valid (o_level.valid),
        .o_level     (o_level.payload),
        .o_status    (status)
    );

endmodule

@@ rtl/core/abl_port_chk.sv @@
`include "audio_block_level_meter_assert.svh"

module abl_port_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_in_last,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input abl_pkg::t_level i_out_payload
);

    logic out_stall;
    logic blk_close;
    logic lvl_in_range;

    assign out_stall    = i_out_valid && !i_out_ready;
    assign blk_close    = i_in_valid && i_in_ready && i_in_last;
    assign lvl_in_range = (i_out_payload.rms_level <= abl_pkg::FULL_SCALE)
                          && (i_out_payload.peak_level <= abl_pkg::FULL_SCALE);

    // hold a stalled item
    `ABL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `ABL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_out_payload))
    // levels never exceed full scale
    `ABL_ASSERT_SAME(a_lvl_range, i_clk, i_rst_n, i_out_valid, lvl_in_range)
    // stop taking frames once a block closes
    `ABL_ASSERT_NEXT(a_blk_end_busy, i_clk, i_rst_n, blk_close, !i_in_ready)

endmodule

bind audio_block_level_meter abl_port_chk u_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_frame.valid),
    .i_in_ready    (i_frame.ready),
    .i_in_last     (i_frame.payload.last_in_block),
    .i_out_valid   (o_level.valid),
    .i_out_ready   (o_level.ready),
    .i_out_payload (o_level.payload)
);

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abl_pkg::*;

    // Frames a block can sum before the counter stops advancing.
    localparam int FRAME_LIMIT = MAX_FRAMES_DEF;
    // Cycles to let the divider and root finish after the last frame.
    localparam int SETTLE_CYCLES = 120;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Frames per random segment.
    localparam int SEGMENT_FRAMES = 112;

    // Predicts the level results from accepted frames and register writes.
    class level_scoreboard;
        logic [CH_W-1:0]  n_channels;
        logic [THR_W-1:0] clip_thr;
        logic [SUM_W-1:0] sq_acc;
        logic [LVL_W-1:0] peak_acc;
        logic [16:0]      frames_acc;
        logic             clip_sticky;
        t_level           level_q[$];
        int               mismatches;
        int               levels_checked;
        int               frames_seen;
        int               writes_seen;

        function new();
            n_channels     = ACT_CH_RST;
            clip_thr       = CLIP_THR_RST;
            sq_acc         = '0;
            peak_acc       = '0;
            frames_acc     = '0;
            clip_sticky    = 1'b0;
            mismatches     = 0;
            levels_checked = 0;
            frames_seen    = 0;
            writes_seen    = 0;
        endfunction

        function void note_config(t_cfg_wr wr);
            writes_seen++;
            case (wr.index)
                REG_ACTIVE_CHANNELS: n_channels = wr.data[CH_W-1:0];
                REG_CLIP_THRESHOLD:  clip_thr   = wr.data;
                default: ;
            endcase
        endfunction

        function logic [LVL_W-1:0] magnitude(logic signed [SMP_W-1:0] s);
            logic [SMP_W-1:0] u;
            u = s;
            return s[SMP_W-1] ? (~u + 1'b1) : u;
        endfunction

        function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // Build the root one bit at a time, keeping a bit when its square still fits.
        function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] trial;
            res = '0;
            for (int b = 29; b >= 0; b--) begin
                trial = res | (64'd1 << b);
                if (trial * trial <= x)
                    res = trial;
            end
            return res;
        endfunction

        function void note_frame(t_frame f);
            int               ch;
            logic [LVL_W-1:0] m1;
            logic [LVL_W-1:0] m2;
            logic             room;
            logic [63:0]      divisor;
            logic [63:0]      root;
            t_level           lvl;
            frames_seen++;
            ch   = (n_channels > CH_MAX) ? int'(CH_MAX) : int'(n_channels);
            m1   = magnitude(f.first_sample);
            m2   = magnitude(f.second_sample);
            room = frames_acc < 17'(FRAME_LIMIT);
            if (ch >= 1) begin
                if (room)
                    sq_acc = add_sat(sq_acc, SUM_W'(m1) * SUM_W'(m1));
                if (m1 > peak_acc)
                    peak_acc = m1;
                if (ch >= 2) begin
                    if (room)
                        sq_acc = add_sat(sq_acc, SUM_W'(m2) * SUM_W'(m2));
                    if (m2 > peak_acc)
                        peak_acc = m2;
                end
                if (room)
                    frames_acc++;
            end
            if (!f.last_in_block)
                return;
            lvl = '0;
            if (ch != 0) begin
                divisor = 64'(frames_acc) * 64'(ch);
                root    = root_floor(divisor != 0 ? 64'(sq_acc) / divisor : 64'd0);
                lvl.rms_level  = (root > 64'(FULL_SCALE)) ? FULL_SCALE : root[LVL_W-1:0];
                lvl.peak_level = peak_acc;
                if (peak_acc >= clip_thr)
                    clip_sticky = 1'b1;
            end
            lvl.clip_flag = clip_sticky;
            level_q.push_back(lvl);
            sq_acc     = '0;
            peak_acc   = '0;
            frames_acc = '0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_level(t_level got);
            t_level want;
            if (level_q.size() == 0) begin
                report("unexpected level item", 32'(got.rms_level), 0);
                return;
            end
            want = level_q.pop_front();
            levels_checked++;
            if (got.rms_level !== want.rms_level)
                report("rms_level", 32'(got.rms_level), 32'(want.rms_level));
            if (got.peak_level !== want.peak_level)
                report("peak_level", 32'(got.peak_level), 32'(want.peak_level));
            if (got.clip_flag !== want.clip_flag)
                report("clip_flag", 32'(got.clip_flag), 32'(want.clip_flag));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    abl_stream_if #(.T_PAYLOAD(t_frame))  frame_if ();
    abl_stream_if #(.T_PAYLOAD(t_level))  level_if ();
    abl_stream_if #(.T_PAYLOAD(t_cfg_wr)) cfg_if ();

    level_scoreboard sb = new();

    // Idle percentages for each side; the main sequence changes them per phase.
    int send_idle = 25;
    int recv_idle = 70;
    // The sender bumps hold_asks; the receiver process counts the hold-off itself.
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    audio_block_level_meter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_level (level_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Note every accepted item in one place so the order among items taken together is fixed:
    // register writes first, then frames, then results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.note_config(cfg_if.payload);
            if (frame_if.valid && frame_if.ready)
                sb.note_frame(frame_if.payload);
            if (level_if.valid && level_if.ready)
                sb.check_level(level_if.payload);
        end
    end

    // Receiver: random back-pressure, or a long hold-off when the sender asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            level_if.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            level_if.ready <= 1'b0;
            hold_seen      <= hold_asks;
            hold_left      <= HOLD_OFF_CYCLES;
        end else begin
            level_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Bail out if the block hangs; sized well past the slowest legal run.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_frame mk_frame(int a, int b, bit last);
        t_frame f;
        f.first_sample  = SMP_W'(a);
        f.second_sample = SMP_W'(b);
        f.last_in_block = last;
        return f;
    endfunction

    // Mix extremes, small values near zero and full-range noise.
    function automatic logic signed [SMP_W-1:0] rand_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(4))
                0: return SMP_W'(-8388608);
                1: return SMP_W'(8388607);
                2: return SMP_W'(0);
                3: return SMP_W'(-1);
                default: return SMP_W'(1);
            endcase
        end else if (sel < 30) begin
            return SMP_W'(int'($urandom_range(512)) - 256);
        end
        return SMP_W'($urandom());
    endfunction

    // Offer one frame, idling first at the sender's rate, and hold it until taken.
    task send_frame(t_frame f);
        while ($urandom_range(99) < send_idle) begin
            frame_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_if.valid   <= 1'b1;
        frame_if.payload <= f;
        @(posedge i_clk);
        while (!frame_if.ready)
            @(posedge i_clk);
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet.
    task drain_levels();
        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.level_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_reg idx, logic [THR_W-1:0] data);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{index: idx, data: data};
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random blocks: mostly short, some medium, a few long.
    task send_blocks(int n_frames);
        int sent;
        int len;
        int sel;
        sent = 0;
        while (sent < n_frames) begin
            sel = $urandom_range(99);
            if (sel < 70)
                len = $urandom_range(1, 6);
            else if (sel < 95)
                len = $urandom_range(7, 30);
            else
                len = $urandom_range(31, 100);
            for (int i = 0; i < len; i++) begin
                send_frame(mk_frame(rand_sample(), rand_sample(), i == len - 1));
                sent++;
            end
        end
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(3))
            0: return '0;
            1: return THR_W'(FULL_SCALE);
            2: return CLIP_THR_RST;
            default: return THR_W'($urandom_range(0, 8388608));
        endcase
    endfunction

    initial begin
        i_rst_n          <= 1'b0;
        frame_if.valid   <= 1'b0;
        frame_if.payload <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.payload   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the first idling mix.
        // Silence with reset settings: all zero, clip still clear.
        send_frame(mk_frame(0, 0, 1));
        // Peak one step below the default threshold must not clip.
        send_frame(mk_frame(8384414, -100, 0));
        send_frame(mk_frame(-8384414, 5, 1));
        drain_levels();
        // Zero channels: full-scale input still reports zeros and keeps the latch.
        write_reg(REG_ACTIVE_CHANNELS, 0);
        send_frame(mk_frame(-8388608, 8388607, 1));
        drain_levels();
        // One channel: the second sample must be ignored.
        write_reg(REG_ACTIVE_CHANNELS, 1);
        send_frame(mk_frame(100, -8388608, 1));
        send_frame(mk_frame(-1, 1, 0));
        send_frame(mk_frame(1, -1, 1));
        drain_levels();
        // Threshold zero: a silent block has peak equal to the threshold and clips.
        write_reg(REG_CLIP_THRESHOLD, 0);
        write_reg(REG_ACTIVE_CHANNELS, 2);
        send_frame(mk_frame(0, 0, 1));
        drain_levels();
        // Channel count above two meters two channels; most negative sample.
        write_reg(REG_CLIP_THRESHOLD, THR_W'(FULL_SCALE));
        write_reg(REG_ACTIVE_CHANNELS, 3);
        send_frame(mk_frame(-8388608, 0, 0));
        send_frame(mk_frame(8388607, -8388608, 1));
        drain_levels();
        // Channel count changed mid-block: divisor shrinks and the RMS saturates.
        write_reg(REG_ACTIVE_CHANNELS, 2);
        send_frame(mk_frame(-8388608, -8388608, 0));
        send_frame(mk_frame(-8388608, -8388608, 0));
        drain_levels();
        write_reg(REG_ACTIVE_CHANNELS, 1);
        send_frame(mk_frame(0, 0, 1));
        drain_levels();
        write_reg(REG_CLIP_THRESHOLD, CLIP_THR_RST);
        write_reg(REG_ACTIVE_CHANNELS, 2);
        send_frame(mk_frame(8388607, 8388607, 1));
        drain_levels();

        // Random part: three idling mixes, new settings per segment.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 25; recv_idle = 70; end
                1: begin send_idle = 70; recv_idle = 25; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                drain_levels();
                write_reg(REG_ACTIVE_CHANNELS, THR_W'($urandom_range(3)));
                write_reg(REG_CLIP_THRESHOLD, pick_threshold());
                // Stall the output for a long stretch while frames keep coming.
                if (phase == 2 && seg == 1)
                    hold_asks++;
                send_blocks(SEGMENT_FRAMES);
            end
        end
        drain_levels();

        $display("covered %0d frames, %0d level results, %0d register writes",
                 sb.frames_seen, sb.levels_checked, sb.writes_seen);
        $display("idling mixes, channel and threshold corners, long output hold-off; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.level_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
